FILE: sv/rtim_pkg.sv
package rtim_pkg;

	localparam int MAX_NODES    = 1024;
	localparam int FANOUT       = 16;
	localparam int NIB_W        = 4;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int CNT_W        = $clog2(MAX_NODES + 1);
	localparam int ADDR_W       = NODE_W + NIB_W;
	localparam int DEPTH        = MAX_NODES * FANOUT;
	localparam int WORD_W       = 32;
	localparam int LVL_W        = 3;
	localparam int INNER_LEVELS = 7;
	localparam int TOP_OFFSET   = 8;

	localparam logic [1:0] MODE_GET   = 2'd0;
	localparam logic [1:0] MODE_PUT   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [WORD_W-1:0] key;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic                     status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ZERO,
		ST_READ,
		ST_EVAL,
		ST_LINK,
		ST_LEAF_RD,
		ST_LEAF_EVAL,
		ST_LEAF_WR,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_FAIL,
		RES_READ
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     init_walk;
		logic     rd_en;
		logic     wr_link;
		logic     wr_zero;
		logic     wr_value;
		logic     sweep_clr;
		logic     alloc_done;
		logic     descend;
		logic     level_dec;
		logic     clear_count;
		logic     res_set;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       count_zero;
		logic       pool_full;
		logic       absent;
		logic       level_one;
		logic       sweep_last;
	} stat_t;

	// Digit of the key used at a level; level zero picks the leaf word.
	// The top digit is offset so that keys sort in signed order.
	function automatic logic [NIB_W-1:0] nibble_at(logic [WORD_W-1:0] u,
			logic [LVL_W-1:0] lvl);
		logic [NIB_W-1:0] c;
		c = u[{lvl, 2'b00} +: NIB_W];
		if (lvl == LVL_W'(INNER_LEVELS)) begin
			c = c + NIB_W'(TOP_OFFSET);
		end
		return c;
	endfunction

endpackage

FILE: sv/rtim_ctrl.sv
module rtim_ctrl
	import rtim_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   rooting_q, rooting_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rooting_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rooting_q <= rooting_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		rooting_d = rooting_q;
		cmd       = '0;
		cmd.res_sel = RES_OK;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.init_walk = 1'b1;
				case (stat.mode)
					MODE_GET: begin
						if (stat.count_zero) begin
							cmd.res_set = 1'b1;
							state_d     = ST_FINISH;
						end else begin
							state_d = ST_READ;
						end
					end
					MODE_PUT: begin
						if (stat.count_zero && stat.pool_full) begin
							cmd.res_set = 1'b1;
							cmd.res_sel = RES_FAIL;
							state_d     = ST_FINISH;
						end else if (stat.count_zero) begin
							rooting_d     = 1'b1;
							cmd.sweep_clr = 1'b1;
							state_d       = ST_ZERO;
						end else begin
							state_d = ST_READ;
						end
					end
					MODE_CLEAR: begin
						cmd.clear_count = 1'b1;
						cmd.res_set     = 1'b1;
						state_d         = ST_FINISH;
					end
					default: begin
						cmd.res_set = 1'b1;
						state_d     = ST_FINISH;
					end
				endcase
			end
			ST_ZERO: begin
				cmd.wr_zero = 1'b1;
				if (stat.sweep_last) begin
					cmd.alloc_done = 1'b1;
					if (rooting_q) begin
						rooting_d = 1'b0;
						state_d   = ST_READ;
					end else begin
						cmd.level_dec = 1'b1;
						state_d       = stat.level_one ? ST_LEAF_WR : ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.absent) begin
					if (stat.mode == MODE_GET) begin
						cmd.res_set = 1'b1;
						state_d     = ST_FINISH;
					end else if (stat.pool_full) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_FAIL;
						state_d     = ST_FINISH;
					end else begin
						state_d = ST_LINK;
					end
				end else begin
					cmd.descend   = 1'b1;
					cmd.level_dec = 1'b1;
					if (!stat.level_one) begin
						state_d = ST_READ;
					end else if (stat.mode == MODE_GET) begin
						state_d = ST_LEAF_RD;
					end else begin
						state_d = ST_LEAF_WR;
					end
				end
			end
			ST_LINK: begin
				// The new node's index goes into the empty slot before it is cleared.
				cmd.wr_link   = 1'b1;
				cmd.sweep_clr = 1'b1;
				state_d       = ST_ZERO;
			end
			ST_LEAF_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LEAF_EVAL;
			end
			ST_LEAF_EVAL: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_READ;
				state_d     = ST_FINISH;
			end
			ST_LEAF_WR: begin
				cmd.wr_value = 1'b1;
				cmd.res_set  = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/rtim_dp.sv
module rtim_dp
	import rtim_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output rsp_t  rsp
);

	logic [WORD_W-1:0] mem [DEPTH];

	req_t              item_q;
	logic [CNT_W-1:0]  count_q;
	logic [NODE_W-1:0] node_q;
	logic [LVL_W-1:0]  level_q;
	logic [NIB_W-1:0]  sweep_q;
	logic [WORD_W-1:0] rdata_q;
	rsp_t              res_q;
	rsp_t              rsp_q;

	logic [ADDR_W-1:0] walk_addr;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic              we;

	assign walk_addr = {node_q, nibble_at(item_q.key, level_q)};

	always_comb begin
		we    = cmd.wr_link | cmd.wr_zero | cmd.wr_value;
		waddr = walk_addr;
		wdata = item_q.value;
		if (cmd.wr_zero) begin
			waddr = {count_q[NODE_W-1:0], sweep_q};
			wdata = '0;
		end else if (cmd.wr_link) begin
			wdata = WORD_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[walk_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.alloc_done) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.init_walk) begin
			node_q  <= '0;
			level_q <= LVL_W'(INNER_LEVELS);
		end else begin
			if (cmd.alloc_done) begin
				node_q <= count_q[NODE_W-1:0];
			end else if (cmd.descend) begin
				node_q <= rdata_q[NODE_W-1:0];
			end
			if (cmd.level_dec) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
		if (cmd.sweep_clr) begin
			sweep_q <= '0;
		end else if (cmd.wr_zero) begin
			sweep_q <= sweep_q + NIB_W'(1);
		end
		if (cmd.res_set) begin
			case (cmd.res_sel)
				RES_FAIL: res_q <= '{read_value: '0, status: 1'b1};
				RES_READ: res_q <= '{read_value: rdata_q, status: 1'b0};
				default:  res_q <= '{read_value: '0, status: 1'b0};
			endcase
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign stat.mode       = item_q.mode;
	assign stat.count_zero = (count_q == '0);
	assign stat.pool_full  = (count_q >= CNT_W'(MAX_NODES));
	// A link to a node outside the pool in use counts as no link.
	assign stat.absent     = (rdata_q == '0) || (rdata_q >= WORD_W'(count_q));
	assign stat.level_one  = (level_q == LVL_W'(1));
	assign stat.sweep_last = (sweep_q == '1);

	assign rsp = rsp_q;

endmodule

FILE: sv/radix16_trie_int_map.sv
// Map from signed 32-bit key to 32-bit value, kept as a 16-ary radix trie in a pool of
// MAX_NODES nodes of 16 words, held in one single-port memory. One transfer on req gives
// exactly one transfer on rsp: get returns the stored value (0 when the path is absent),
// put stores the value and sets status when the pool runs out (nodes already made stay),
// clear empties the pool. Work on one item at a time; the walk does seven dependent memory
// reads, and a put adds, for every node it allocates, one link write and a sweep that
// zeroes the new node, or only the sweep for the root. The next request is taken as soon
// as the result sits in the output register, even if it is not yet taken.
module radix16_trie_int_map
	import rtim_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	rtim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtim_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
